FILE: rtl/ubx_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// UBX deframer assertion macros
// Shared helpers for the concurrent checks on the deframer ports.
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_DEFRAMER_DEFINES_SVH
`define UBX_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UBX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define UBX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ubx_pkg.sv
// ----------------------------------------------------------------------------
// UBX deframer package
// Result record and fixed codes shared by the deframer modules.
// ----------------------------------------------------------------------------
package ubx_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam logic [1:0] KIND_NONFRAME = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;
	localparam logic [1:0] KIND_PREAMBLE = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [7:0]  msg_class;
		logic [7:0]  msg_id;
		logic [15:0] payload_len;
		logic [15:0] byte_index;
		logic [15:0] checksum_read;
		logic        last;
	} ubx_result_t;

endpackage

FILE: rtl/ubx_parse.sv
// ----------------------------------------------------------------------------
// UBX byte parser
// Frame state machine: one byte in, at most one result out per transfer.
// ----------------------------------------------------------------------------
module ubx_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           data_byte,
	output logic                 res_valid,
	output ubx_pkg::ubx_result_t res
);

	localparam logic [2:0] PH_SEARCH  = 3'd0;
	localparam logic [2:0] PH_CLASS   = 3'd1;
	localparam logic [2:0] PH_ID      = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_LEN_HI  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_CK_LO   = 3'd6;
	localparam logic [2:0] PH_CK_HI   = 3'd7;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  ck_lo_q, ck_lo_d;
	logic [15:0] full_len;
	logic        is_last;

	assign full_len = {data_byte, len_q[7:0]};
	assign is_last  = ({1'b0, count_q} + 17'd1) == {1'b0, len_q};

	always_comb begin
		phase_d   = phase_q;
		prev_d    = prev_q;
		class_d   = class_q;
		id_d      = id_q;
		len_d     = len_q;
		count_d   = count_q;
		ck_lo_d   = ck_lo_q;
		res_valid = 1'b0;
		res       = '0;
		if (take) begin
			unique case (phase_q)
				PH_SEARCH: begin
					res_valid = 1'b1;
					if (prev_q == ubx_pkg::SYNC_FIRST && data_byte == ubx_pkg::SYNC_SECOND) begin
						phase_d  = PH_CLASS;
						res.kind = ubx_pkg::KIND_PREAMBLE;
					end else begin
						prev_d       = data_byte;
						res.kind     = ubx_pkg::KIND_NONFRAME;
						res.out_byte = data_byte;
					end
				end
				PH_CLASS: begin
					class_d = data_byte;
					phase_d = PH_ID;
				end
				PH_ID: begin
					id_d    = data_byte;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = {8'd0, data_byte};
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d   = full_len;
					count_d = '0;
					phase_d = (full_len == 16'd0) ? PH_CK_LO : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					count_d         = count_q + 16'd1;
					if (is_last) begin
						phase_d = PH_CK_LO;
					end
					res_valid       = 1'b1;
					res.kind        = ubx_pkg::KIND_PAYLOAD;
					res.out_byte    = data_byte;
					res.msg_class   = class_q;
					res.msg_id      = id_q;
					res.payload_len = len_q;
					res.byte_index  = count_q;
					res.last        = is_last;
				end
				PH_CK_LO: begin
					ck_lo_d = data_byte;
					phase_d = PH_CK_HI;
				end
				PH_CK_HI: begin
					// drop the sync history so a trailing 0xB5 cannot pair
					phase_d           = PH_SEARCH;
					prev_d            = 8'd0;
					res_valid         = 1'b1;
					res.kind          = ubx_pkg::KIND_COMPLETE;
					res.msg_class     = class_q;
					res.msg_id        = id_q;
					res.payload_len   = len_q;
					res.checksum_read = {data_byte, ck_lo_q};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			prev_q  <= 8'd0;
			class_q <= 8'd0;
			id_q    <= 8'd0;
			len_q   <= 16'd0;
			count_q <= 16'd0;
			ck_lo_q <= 8'd0;
		end else begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			class_q <= class_d;
			id_q    <= id_d;
			len_q   <= len_d;
			count_q <= count_d;
			ck_lo_q <= ck_lo_d;
		end
	end

endmodule

FILE: rtl/ubx_outbuf.sv
// ----------------------------------------------------------------------------
// UBX result buffer
// Output register with one skid entry; stalls the input only when both hold.
// ----------------------------------------------------------------------------
module ubx_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ubx_pkg::ubx_result_t push_data,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ubx_pkg::ubx_result_t out_data
);

	logic                 out_valid_q;
	logic                 skid_valid_q;
	ubx_pkg::ubx_result_t out_data_q;
	ubx_pkg::ubx_result_t skid_data_q;
	logic                 pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (pop && skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (pop || !out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (pop && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (pop || !out_valid_q) begin
			if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

FILE: rtl/ubx_frame_deframer.sv
// ----------------------------------------------------------------------------
// UBX frame deframer
// Byte-stream parser that finds UBX frames and reports their parts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte (data_byte) per transfer, in_valid /
//   in_stall. Output channel: one result record per transfer, out_valid /
//   out_stall, with fields kind, out_byte, msg_class, msg_id, payload_len,
//   byte_index, checksum_read and last.
//   Bytes outside a frame come out as non-frame bytes, the second sync byte
//   as preamble found, each payload byte with its index and last mark, and
//   the second checksum byte as frame complete. Class, id, length and the
//   first checksum byte produce no result.
//   Each result is registered in the output register, or in the skid entry
//   while the receiver stalls. Throughput: one byte per cycle while in_stall
//   is low, set by the frame state machine feeding the output register.
//   Stall: while the receiver stalls, the input keeps taking bytes until a
//   second result is waiting; that result parks in the skid entry and
//   in_stall stays high while the skid entry is occupied.
//   Reset (arst_n low): the parser returns to preamble search with a cleared
//   sync history, and both output entries are emptied.
// ----------------------------------------------------------------------------
module ubx_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [7:0]  msg_class,
	output logic [7:0]  msg_id,
	output logic [15:0] payload_len,
	output logic [15:0] byte_index,
	output logic [15:0] checksum_read,
	output logic        last
);

	logic                 take;
	logic                 res_valid;
	logic                 buf_full;
	ubx_pkg::ubx_result_t res;
	ubx_pkg::ubx_result_t out_data;

	// hold the input only while the skid entry is occupied
	assign in_stall = buf_full;
	assign take     = in_valid && !buf_full;

	// advance the frame state machine on every input transfer
	ubx_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	// register the result; park it in the skid entry if the receiver stalls
	ubx_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind          = out_data.kind;
	assign out_byte      = out_data.out_byte;
	assign msg_class     = out_data.msg_class;
	assign msg_id        = out_data.msg_id;
	assign payload_len   = out_data.payload_len;
	assign byte_index    = out_data.byte_index;
	assign checksum_read = out_data.checksum_read;
	assign last          = out_data.last;

endmodule

FILE: rtl/ubx_chk.sv
// ----------------------------------------------------------------------------
// UBX deframer port checker
// Concurrent checks on the deframer ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "ubx_frame_deframer_defines.svh"

module ubx_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [7:0]  out_byte,
	input logic [7:0]  msg_class,
	input logic [15:0] payload_len,
	input logic [15:0] byte_index,
	input logic [15:0] checksum_read,
	input logic        last
);

	// a stalled result holds
	`UBX_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(out_byte) && $stable(byte_index) && $stable(checksum_read), "stalled result changed")

	// the final payload byte sits at length minus one
	`UBX_ASSERT_NOW(a_last_index, out_valid && kind == ubx_pkg::KIND_PAYLOAD && last, byte_index == payload_len - 16'd1, "last mark at wrong index")

	// non-frame bytes carry no frame header
	`UBX_ASSERT_NOW(a_nonframe, out_valid && kind == ubx_pkg::KIND_NONFRAME, msg_class == 8'd0 && payload_len == 16'd0 && !last, "non-frame byte carries frame fields")

	// preamble report carries nothing else
	`UBX_ASSERT_NOW(a_preamble, out_valid && kind == ubx_pkg::KIND_PREAMBLE, out_byte == 8'd0 && checksum_read == 16'd0 && !last, "preamble report carries data")

endmodule

bind ubx_frame_deframer ubx_chk u_ubx_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.out_byte      (out_byte),
	.msg_class     (msg_class),
	.payload_len   (payload_len),
	.byte_index    (byte_index),
	.checksum_read (checksum_read),
	.last          (last)
);

FILE: tb/sv/tb_deframe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX deframer scoreboard
// Predicts the result record, if any, for every byte the deframer takes in and
// checks the records it sends out, oldest first.
// ----------------------------------------------------------------------------
package tb_deframe_pkg;

	import ubx_pkg::*;

	typedef enum logic [2:0] {
		SEEK_SYNC,
		TAKE_CLASS,
		TAKE_ID,
		TAKE_LEN_LO,
		TAKE_LEN_HI,
		TAKE_PAYLOAD,
		TAKE_CK_LO,
		TAKE_CK_HI
	} deframe_stage_t;

	class deframe_scoreboard;

		deframe_stage_t stage;
		logic [7:0]     prev_byte;
		logic [7:0]     cur_class;
		logic [7:0]     cur_id;
		logic [15:0]    cur_len;
		logic [15:0]    payload_seen;
		logic [7:0]     ck_low;

		ubx_result_t    frame_reports[$];
		int unsigned    bytes_in;
		int unsigned    checked;
		int unsigned    errors;
		int unsigned    kind_count[4];

		function new();
			stage        = SEEK_SYNC;
			prev_byte    = '0;
			cur_class    = '0;
			cur_id       = '0;
			cur_len      = '0;
			payload_seen = '0;
			ck_low       = '0;
			bytes_in     = 0;
			checked      = 0;
			errors       = 0;
			foreach (kind_count[k])
				kind_count[k] = 0;
		endfunction

		function bit searching();
			return stage == SEEK_SYNC;
		endfunction

		// A 0x62 now would start a frame.
		function bit sync_armed();
			return stage == SEEK_SYNC && prev_byte == SYNC_FIRST;
		endfunction

		function int unsigned pending();
			return frame_reports.size();
		endfunction

		// Advance the frame parser by one transferred byte and queue its record.
		function void deframe_byte(logic [7:0] b);
			ubx_result_t rec;
			bit          emits;
			rec   = '0;
			emits = 1'b0;
			bytes_in++;
			case (stage)
				SEEK_SYNC: begin
					emits = 1'b1;
					if (prev_byte == SYNC_FIRST && b == SYNC_SECOND) begin
						rec.kind = KIND_PREAMBLE;
						stage    = TAKE_CLASS;
					end else begin
						rec.kind     = KIND_NONFRAME;
						rec.out_byte = b;
						prev_byte    = b;
					end
				end
				TAKE_CLASS: begin
					cur_class = b;
					stage     = TAKE_ID;
				end
				TAKE_ID: begin
					cur_id = b;
					stage  = TAKE_LEN_LO;
				end
				TAKE_LEN_LO: begin
					cur_len = {8'h00, b};
					stage   = TAKE_LEN_HI;
				end
				TAKE_LEN_HI: begin
					cur_len      = {b, cur_len[7:0]};
					payload_seen = '0;
					stage        = (cur_len == 16'h0000) ? TAKE_CK_LO : TAKE_PAYLOAD;
				end
				TAKE_PAYLOAD: begin
					emits           = 1'b1;
					rec.kind        = KIND_PAYLOAD;
					rec.out_byte    = b;
					rec.msg_class   = cur_class;
					rec.msg_id      = cur_id;
					rec.payload_len = cur_len;
					rec.byte_index  = payload_seen;
					rec.last        = ({1'b0, payload_seen} + 17'd1 == {1'b0, cur_len});
					payload_seen    = payload_seen + 16'd1;
					if (rec.last)
						stage = TAKE_CK_LO;
				end
				TAKE_CK_LO: begin
					ck_low = b;
					stage  = TAKE_CK_HI;
				end
				default: begin
					emits             = 1'b1;
					rec.kind          = KIND_COMPLETE;
					rec.msg_class     = cur_class;
					rec.msg_id        = cur_id;
					rec.payload_len   = cur_len;
					rec.checksum_read = {b, ck_low};
					prev_byte         = '0;
					stage             = SEEK_SYNC;
				end
			endcase
			if (emits)
				frame_reports.push_back(rec);
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		task compare_field(string field, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
					checked, field, got, want));
		endtask

		task check_report(ubx_result_t got);
			ubx_result_t want;
			checked++;
			if (frame_reports.size() == 0) begin
				report($sformatf("result %0d (kind %0d) arrived with none expected",
					checked, got.kind));
				return;
			end
			want = frame_reports.pop_front();
			compare_field("kind", 16'(got.kind), 16'(want.kind));
			compare_field("out_byte", 16'(got.out_byte), 16'(want.out_byte));
			compare_field("msg_class", 16'(got.msg_class), 16'(want.msg_class));
			compare_field("msg_id", 16'(got.msg_id), 16'(want.msg_id));
			compare_field("payload_len", got.payload_len, want.payload_len);
			compare_field("byte_index", got.byte_index, want.byte_index);
			compare_field("checksum_read", got.checksum_read, want.checksum_read);
			compare_field("last", 16'(got.last), 16'(want.last));
			kind_count[want.kind]++;
		endtask

		task drain_check();
			if (frame_reports.size() != 0)
				report($sformatf("%0d expected results never arrived",
					frame_reports.size()));
		endtask

	endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame deframer testbench
// Feeds byte streams of noise, well-formed frames and broken frames into the
// deframer under random idling and stalls, predicts every result record and
// checks each transfer out against the prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;

	import ubx_pkg::*;
	import tb_deframe_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 50_000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned RANDOM_BYTES = 700;
	localparam int unsigned IDLE_PCT     = 30;
	localparam int unsigned DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [7:0]  msg_class;
	logic [7:0]  msg_id;
	logic [15:0] payload_len;
	logic [15:0] byte_index;
	logic [15:0] checksum_read;
	logic        last;

	deframe_scoreboard sb = new();

	// steady: neither side idles. hold_wanted asks the receiver for one long
	// hold-off; the receiver counts it and raises hold_done when it is over.
	bit          steady      = 1'b0;
	bit          hold_wanted = 1'b0;
	bit          hold_done;
	int unsigned cycles      = 0;

	ubx_frame_deframer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.out_byte      (out_byte),
		.msg_class     (msg_class),
		.msg_id        (msg_id),
		.payload_len   (payload_len),
		.byte_index    (byte_index),
		.checksum_read (checksum_read),
		.last          (last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a healthy run ends far below this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected",
				cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: drive out_stall at the falling edge. The one long hold-off is
	// counted here so the sender keeps offering bytes while it runs.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
				if (hold_left == 0)
					hold_done = 1'b1;
			end else if (hold_wanted && !hold_done) begin
				out_stall <= 1'b1;
				hold_left = HOLD_CYCLES - 1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Check every record transferred out, sampled at the rising edge.
	always @(posedge clk) begin : result_monitor
		ubx_result_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{kind: kind, out_byte: out_byte, msg_class: msg_class,
				msg_id: msg_id, payload_len: payload_len, byte_index: byte_index,
				checksum_read: checksum_read, last: last};
			sb.check_report(seen);
		end
	end

	// Offer one byte and hold it until the deframer takes it. Call at a falling
	// edge; returns at the falling edge after the transfer.
	task automatic push_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.deframe_byte(b);
		@(negedge clk);
	endtask

	// Complete frame: sync pair, header, random payload, checksum.
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
		input logic [15:0] len, input logic [15:0] ck);
		push_byte(SYNC_FIRST);
		push_byte(SYNC_SECOND);
		push_byte(cls);
		push_byte(id);
		push_byte(len[7:0]);
		push_byte(len[15:8]);
		for (int unsigned i = 0; i < len; i++)
			push_byte(8'($urandom));
		push_byte(ck[7:0]);
		push_byte(ck[15:8]);
	endtask

	// Stray bytes between frames, biased toward the sync values. Invert any 0x62
	// that would complete a sync pair so noise never opens a frame.
	task automatic send_noise(input int unsigned count);
		logic [7:0] b;
		for (int unsigned i = 0; i < count; i++) begin
			case ($urandom_range(4))
				0:       b = SYNC_FIRST;
				1:       b = SYNC_SECOND;
				default: b = 8'($urandom);
			endcase
			if (sb.sync_armed() && b == SYNC_SECOND)
				b = ~b;
			push_byte(b);
		end
	endtask

	function automatic logic [15:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return 16'd0;
		if (r < 94)
			return 16'($urandom_range(1, 12));
		return 16'($urandom_range(200, 300));
	endfunction

	initial begin : stimulus
		logic [7:0]  opening [23];
		logic [15:0] len;
		int unsigned start_bytes;
		int unsigned done_bytes;
		int unsigned cut;

		// Noise extremes, repeated first sync byte, empty payload, checksum
		// ending in 0xB5 followed by 0x62, a broken sync pair, one-byte payload.
		opening = '{8'h00, 8'hFF, 8'hB5, 8'hB5, 8'h62,
			8'hFF, 8'h00, 8'h00, 8'h00, 8'h34, 8'hB5,
			8'h62, 8'hB5, 8'h00,
			8'hB5, 8'h62, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF};

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i])
			push_byte(opening[i]);

		// Random part: mostly well-formed frames with random content, the rest
		// noise and broken sequences. Every branch leaves the parser searching.
		start_bytes = sb.bytes_in;
		done_bytes  = 0;
		while (done_bytes < RANDOM_BYTES) begin
			// hold a stretch with no idling on either side
			steady = (done_bytes >= 400 && done_bytes < 520);
			if (!hold_wanted && done_bytes >= 150) begin
				// Long receiver hold-off while a big payload keeps coming.
				hold_wanted = 1'b1;
				send_frame(8'($urandom), 8'($urandom), 16'd64, 16'($urandom));
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: begin
						send_noise($urandom_range(0, 3));
						send_frame(8'($urandom), 8'($urandom), pick_length(),
							16'($urandom));
					end
					6: begin
						// repeated first sync byte ahead of the pair
						if (sb.sync_armed())
							push_byte(8'h00);
						push_byte(SYNC_FIRST);
						send_frame(8'($urandom), 8'($urandom), pick_length(),
							16'($urandom));
					end
					7: begin
						// checksum ends in 0xB5; the 0x62 after it stays noise
						send_frame(8'($urandom), 8'($urandom), pick_length(),
							{SYNC_FIRST, 8'($urandom)});
						push_byte(SYNC_SECOND);
					end
					8:
						send_noise($urandom_range(1, 6));
					default: begin
						// cut a frame short, then stream filler until it closes
						len = 16'($urandom_range(4, 12));
						cut = $urandom_range(0, len - 1);
						push_byte(SYNC_FIRST);
						push_byte(SYNC_SECOND);
						push_byte(8'($urandom));
						push_byte(8'($urandom));
						push_byte(len[7:0]);
						push_byte(len[15:8]);
						for (int unsigned i = 0; i < cut; i++)
							push_byte(8'($urandom));
						while (!sb.searching())
							push_byte(8'($urandom));
					end
				endcase
			end
			done_bytes = sb.bytes_in - start_bytes;
		end

		// Closing frame at full rate on both sides.
		steady = 1'b1;
		send_frame(8'h5A, 8'hA5, 16'd32, 16'h5AA5);
		steady = 1'b0;
		send_noise(4);

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.drain_check();

		$display("Run covered %0d bytes in and %0d records out, %0d mismatches",
			sb.bytes_in, sb.checked, sb.errors);
		$display("  non-frame %0d, preamble %0d, payload %0d, complete %0d",
			sb.kind_count[KIND_NONFRAME], sb.kind_count[KIND_PREAMBLE],
			sb.kind_count[KIND_PAYLOAD], sb.kind_count[KIND_COMPLETE]);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
